// ===== design/vbft_pkg.sv =====
// ============================================================================
// vbft_pkg: shared types and constants for the volume bucket flow toxicity block
// Field widths, register indexes, reset values and the job word passed
// from the classifier to the bucket/window engine.
// ============================================================================
package vbft_pkg;

  localparam int PRICE_W = 32;
  localparam int VOL_W   = 32;
  localparam int ACC_W   = 40;
  localparam int Q_W     = 24;
  localparam int FRAC_W  = 16;
  localparam int FILL_W  = 9;
  localparam int DIV_W   = 32;
  localparam int IDX_W   = 1;

  localparam logic [Q_W-1:0]   Q_MAX   = '1;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam logic [IDX_W-1:0] REG_BUCKET_VOLUME  = 1'b0;
  localparam logic [IDX_W-1:0] REG_WINDOW_BUCKETS = 1'b1;

  localparam logic [VOL_W-1:0]  BUCKET_VOLUME_RESET  = 32'd500;
  localparam logic [FILL_W-1:0] WINDOW_BUCKETS_RESET = 9'd20;
  localparam logic [FILL_W-1:0] WINDOW_MIN           = 9'd2;

  typedef struct packed {
    logic             close;
    logic             sat;
    logic [ACC_W-1:0] diff;
  } job_t;

endpackage

// ===== design/vbft_ram.sv =====
// ============================================================================
// vbft_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module vbft_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/vbft_div.sv =====
// ============================================================================
// vbft_div: restoring divider, one quotient bit per cycle
// Produces a 24-bit quotient from a partial remainder (below the divisor)
// followed by 24 low dividend bits.
// ============================================================================
module vbft_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vbft_pkg::DIV_W-1:0]    rem_init,
  input  logic [vbft_pkg::Q_W-1:0]      low,
  input  logic [vbft_pkg::DIV_W-1:0]    den,
  output logic                          done,
  output logic [vbft_pkg::Q_W-1:0]      quot
);

  localparam int CNT_W = $clog2(vbft_pkg::Q_W);

  logic                       busy;
  logic [CNT_W-1:0]           count;
  logic [vbft_pkg::DIV_W-1:0] rem;
  logic [vbft_pkg::DIV_W-1:0] divisor;
  logic [vbft_pkg::Q_W-1:0]   shift;
  logic [vbft_pkg::DIV_W:0]   trial;
  logic                       fits;

  assign trial = {rem, shift[vbft_pkg::Q_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == CNT_W'(vbft_pkg::Q_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == CNT_W'(vbft_pkg::Q_W - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= rem_init;
      shift   <= low;
      divisor <= den;
      count   <= '0;
    end else if (busy) begin
      rem   <= fits ? vbft_pkg::DIV_W'(trial - {1'b0, divisor})
                    : trial[vbft_pkg::DIV_W-1:0];
      quot  <= {quot[vbft_pkg::Q_W-2:0], fits};
      shift <= {shift[vbft_pkg::Q_W-2:0], 1'b0};
      count <= count + 1'b1;
    end
  end

endmodule

// ===== design/vbft_jobq.sv =====
// ============================================================================
// vbft_jobq: two-entry job queue
// Decouples the trade classifier from the bucket and window engine.
// ============================================================================
module vbft_jobq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  vbft_pkg::job_t       wdata,
  input  logic                 pop,
  output logic                 empty,
  output vbft_pkg::job_t       rdata
);

  vbft_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== design/vbft_front.sv =====
// ============================================================================
// vbft_front: tape event classifier
// Applies the tick rule, accumulates buy, sell and bucket volume, decides
// whether a bucket closes and hands one job per event to the job queue.
// ============================================================================
module vbft_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           kind,
  input  logic [vbft_pkg::PRICE_W-1:0]   price,
  input  logic [vbft_pkg::VOL_W-1:0]     volume,
  input  logic [vbft_pkg::VOL_W-1:0]     bucket_volume,
  output logic                           job_push,
  input  logic                           job_full,
  output vbft_pkg::job_t                 job
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_ADD   = 4'b0010,
    F_CLOSE = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  fstate_t                       state;
  fstate_t                       state_next;
  logic                          in_kind;
  logic [vbft_pkg::PRICE_W-1:0]  in_price;
  logic [vbft_pkg::VOL_W-1:0]    in_volume;
  logic [vbft_pkg::PRICE_W-1:0]  prev_price;
  logic [vbft_pkg::ACC_W-1:0]    bucket_fill;
  logic [vbft_pkg::ACC_W-1:0]    buy_volume;
  logic [vbft_pkg::ACC_W-1:0]    sell_volume;
  logic                          job_close;
  logic [vbft_pkg::ACC_W-1:0]    job_diff;
  logic                          up;
  logic                          down;
  logic                          close;
  logic [vbft_pkg::ACC_W-1:0]    diff;
  logic [vbft_pkg::ACC_W-1:0]    vol_ext;

  function automatic logic [vbft_pkg::ACC_W-1:0] sat_add(
    input logic [vbft_pkg::ACC_W-1:0] acc,
    input logic [vbft_pkg::VOL_W-1:0] vol
  );
    logic [vbft_pkg::ACC_W:0] sum;
    sum = {1'b0, acc} + (vbft_pkg::ACC_W + 1)'(vol);
    return sum[vbft_pkg::ACC_W] ? vbft_pkg::ACC_MAX : sum[vbft_pkg::ACC_W-1:0];
  endfunction

  assign full     = state != F_IDLE;
  assign up       = (prev_price != '0) && (in_price > prev_price);
  assign down     = (prev_price != '0) && (in_price < prev_price);
  assign vol_ext  = vbft_pkg::ACC_W'(bucket_volume);
  assign close    = bucket_fill >= vol_ext;
  assign diff     = (buy_volume >= sell_volume) ? buy_volume - sell_volume
                                                : sell_volume - buy_volume;
  assign job_push = (state == F_PUSH) && !job_full;
  assign job.close = job_close;
  assign job.diff  = job_diff;
  assign job.sat   = job_diff >= {bucket_volume, 8'h00};

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (push) state_next = F_ADD;
      F_ADD:   state_next = in_kind ? F_PUSH : F_CLOSE;
      F_CLOSE: state_next = F_PUSH;
      F_PUSH:  if (!job_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      prev_price  <= '0;
      bucket_fill <= '0;
      buy_volume  <= '0;
      sell_volume <= '0;
    end else begin
      state <= state_next;
      if (state == F_ADD && !in_kind) begin
        prev_price  <= in_price;
        bucket_fill <= sat_add(bucket_fill, in_volume);
        if (!down) begin
          buy_volume <= sat_add(buy_volume, in_volume);
        end
        if (!up) begin
          sell_volume <= sat_add(sell_volume, in_volume);
        end
      end
      if (state == F_CLOSE && close) begin
        bucket_fill <= bucket_fill - vol_ext;
        buy_volume  <= '0;
        sell_volume <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      in_kind   <= kind;
      in_price  <= price;
      in_volume <= volume;
    end
    if (state == F_ADD && in_kind) begin
      job_close <= 1'b0;
      job_diff  <= '0;
    end
    if (state == F_CLOSE) begin
      job_close <= close;
      job_diff  <= diff;
    end
  end

endmodule

// ===== design/vbft_back.sv =====
// ============================================================================
// vbft_back: bucket imbalance and window engine
// Divides or saturates the closed bucket imbalance, updates the sliding
// RAM window and its running total, divides the mean and holds the result.
// ============================================================================
module vbft_back #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_empty,
  output logic                          job_pop,
  input  vbft_pkg::job_t                job,
  input  logic [vbft_pkg::VOL_W-1:0]    bucket_volume,
  input  logic [vbft_pkg::FILL_W-1:0]   window_len,
  output logic                          empty,
  input  logic                          pop,
  output logic [vbft_pkg::Q_W-1:0]      mean_imbalance,
  output logic [vbft_pkg::FILL_W-1:0]   buckets_held
);

  localparam int HEAD_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W   = ((HEAD_W > vbft_pkg::FILL_W) ? HEAD_W : vbft_pkg::FILL_W) + 1;
  localparam int TOTAL_W = vbft_pkg::Q_W + vbft_pkg::FILL_W;
  localparam int LOW_W   = vbft_pkg::ACC_W - vbft_pkg::DIV_W;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_DIVQ   = 6'b000010,
    B_PUSH   = 6'b000100,
    B_MSTART = 6'b001000,
    B_DIVM   = 6'b010000,
    B_EMIT   = 6'b100000
  } bstate_t;

  bstate_t                       state;
  bstate_t                       state_next;
  logic [HEAD_W-1:0]             head;
  logic [vbft_pkg::FILL_W-1:0]   fill;
  logic [TOTAL_W-1:0]            total;
  logic [vbft_pkg::Q_W-1:0]      q_val;
  logic [vbft_pkg::Q_W-1:0]      mean_res;
  logic                          out_valid;
  logic                          out_free;
  logic [vbft_pkg::Q_W-1:0]      old_entry;
  logic [SUM_W-1:0]              slot_sum;
  logic [HEAD_W-1:0]             slot;
  logic [HEAD_W:0]               head_inc;
  logic                          window_full;
  logic                          take_job;
  logic                          div_start;
  logic                          div_done;
  logic [vbft_pkg::DIV_W-1:0]    div_rem;
  logic [vbft_pkg::Q_W-1:0]      div_low;
  logic [vbft_pkg::DIV_W-1:0]    div_den;
  logic [vbft_pkg::Q_W-1:0]      div_quot;

  assign take_job    = (state == B_IDLE) && !job_empty;
  assign job_pop     = take_job;
  assign out_free    = !out_valid || pop;
  assign empty       = !out_valid;
  assign window_full = fill >= window_len;
  assign slot_sum    = SUM_W'(head) + SUM_W'(fill);
  assign slot        = (slot_sum >= SUM_W'(MAX_WINDOW))
                       ? HEAD_W'(slot_sum - SUM_W'(MAX_WINDOW)) : HEAD_W'(slot_sum);
  assign head_inc    = {1'b0, head} + 1'b1;
  assign div_start   = (take_job && job.close && !job.sat) || (state == B_MSTART);

  always_comb begin
    if (state == B_IDLE) begin
      div_rem = job.diff[vbft_pkg::ACC_W-1:LOW_W];
      div_low = {job.diff[LOW_W-1:0], vbft_pkg::FRAC_W'(0)};
      div_den = bucket_volume;
    end else begin
      div_rem = vbft_pkg::DIV_W'(total[TOTAL_W-1:vbft_pkg::Q_W]);
      div_low = total[vbft_pkg::Q_W-1:0];
      div_den = vbft_pkg::DIV_W'(fill);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (take_job) begin
          if (job.close) begin
            state_next = job.sat ? B_PUSH : B_DIVQ;
          end else if (fill != '0) begin
            state_next = B_MSTART;
          end
        end
      end
      B_DIVQ:   if (div_done) state_next = B_PUSH;
      B_PUSH:   state_next = B_MSTART;
      B_MSTART: state_next = B_DIVM;
      B_DIVM:   if (div_done) state_next = B_EMIT;
      B_EMIT:   if (out_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      head      <= '0;
      fill      <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_PUSH) begin
        if (window_full) begin
          total <= total - TOTAL_W'(old_entry) + TOTAL_W'(q_val);
          head  <= (head_inc == (HEAD_W + 1)'(MAX_WINDOW)) ? '0 : head_inc[HEAD_W-1:0];
        end else begin
          total <= total + TOTAL_W'(q_val);
          fill  <= fill + 1'b1;
        end
      end
      if (state == B_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_job && job.close && job.sat) begin
      q_val <= vbft_pkg::Q_MAX;
    end else if (state == B_DIVQ && div_done) begin
      q_val <= div_quot;
    end
    if (state == B_DIVM && div_done) begin
      mean_res <= div_quot;
    end
    if (state == B_EMIT && out_free) begin
      mean_imbalance <= mean_res;
      buckets_held   <= fill;
    end
  end

  vbft_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .low      (div_low),
    .den      (div_den),
    .done     (div_done),
    .quot     (div_quot)
  );

  vbft_ram #(
    .WIDTH (vbft_pkg::Q_W),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (state == B_PUSH),
    .waddr (slot),
    .wdata (q_val),
    .raddr (head),
    .rdata (old_entry)
  );

endmodule

// ===== design/volume_bucket_flow_toxicity.sv =====
// ============================================================================
// volume_bucket_flow_toxicity: volume-bucketed order flow toxicity
// Tick-rule trade classification, volume buckets and a sliding window mean
// of bucket imbalance ratios in unsigned Q8.16.
// ============================================================================
// Each tape event passes through the classifier's add, close and push states
// (a non-trade event skips close) and on through a two-entry job queue. The
// back end takes a job, then divides the imbalance quotient when a bucket
// closes (no division when it saturates), updates the window, divides the
// mean and loads the result, all on one shared radix-2 divider. An event that
// comes before the window holds anything returns to idle with no result. A
// result is offered once the window holds an entry, one result per event, in
// event order.
module volume_bucket_flow_toxicity #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            kind,
  input  logic [vbft_pkg::PRICE_W-1:0]    price,
  input  logic [vbft_pkg::VOL_W-1:0]      volume,
  output logic                            empty,
  input  logic                            pop,
  output logic [vbft_pkg::Q_W-1:0]        mean_imbalance,
  output logic [vbft_pkg::FILL_W-1:0]     buckets_held,
  input  logic                            write_enable,
  input  logic [vbft_pkg::IDX_W-1:0]      write_index,
  input  logic [vbft_pkg::VOL_W-1:0]      write_data
);

  logic [vbft_pkg::VOL_W-1:0]   bucket_volume;
  logic [vbft_pkg::FILL_W-1:0]  window_buckets;
  logic [vbft_pkg::VOL_W-1:0]   eff_volume;
  logic [vbft_pkg::FILL_W-1:0]  window_len;
  logic                         job_push;
  logic                         job_full;
  logic                         job_pop;
  logic                         job_empty;
  vbft_pkg::job_t               job_in;
  vbft_pkg::job_t               job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_volume  <= vbft_pkg::BUCKET_VOLUME_RESET;
      window_buckets <= vbft_pkg::WINDOW_BUCKETS_RESET;
    end else if (write_enable) begin
      case (write_index)
        vbft_pkg::REG_BUCKET_VOLUME:  bucket_volume  <= write_data;
        vbft_pkg::REG_WINDOW_BUCKETS: window_buckets <= write_data[vbft_pkg::FILL_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_volume = (bucket_volume == '0) ? vbft_pkg::VOL_W'(1) : bucket_volume;

  always_comb begin
    if (window_buckets < vbft_pkg::WINDOW_MIN) begin
      window_len = vbft_pkg::WINDOW_MIN;
    end else if (32'(window_buckets) > 32'(MAX_WINDOW)) begin
      window_len = vbft_pkg::FILL_W'(MAX_WINDOW);
    end else begin
      window_len = window_buckets;
    end
  end

  vbft_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .price         (price),
    .volume        (volume),
    .bucket_volume (eff_volume),
    .job_push      (job_push),
    .job_full      (job_full),
    .job           (job_in)
  );

  vbft_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_in),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_out)
  );

  vbft_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .job            (job_out),
    .bucket_volume  (eff_volume),
    .window_len     (window_len),
    .empty          (empty),
    .pop            (pop),
    .mean_imbalance (mean_imbalance),
    .buckets_held   (buckets_held)
  );

  a_result_has_buckets: assert property (@(posedge clk) disable iff (rst)
    !empty |-> buckets_held != '0)
    else $error("result offered with an empty window");

  a_job_push_not_full: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_job_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job popped from an empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("classifier took a word without going busy");

endmodule
